// ===== sv/tes_pkg.sv =====
// Package with the shared word types and constants of the triangle element stiffness block.
`timescale 1ns / 1ps
package tes_pkg;

   localparam int COORD_FIELD_W = 32;
   localparam int COEF_FIELD_W  = 48;
   localparam int AREA_W        = 64;

   // Binary point shifts of the three kinds of quotient.
   localparam int K_SHIFT     = 23;
   localparam int ALPHA_SHIFT = 24;
   localparam int SLOPE_SHIFT = 40;

   // Divider lanes of one row.
   localparam int LANES       = 6;
   localparam int LANE_K0     = 0;
   localparam int LANE_K1     = 1;
   localparam int LANE_K2     = 2;
   localparam int LANE_ALPHA  = 3;
   localparam int LANE_BETA   = 4;
   localparam int LANE_GAMMA  = 5;

   localparam logic [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
   localparam logic [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ROW_V0 = 2'd0,
      ROW_V1 = 2'd1,
      ROW_V2 = 2'd2
   } row_type;

   typedef struct packed {
      logic signed [COORD_FIELD_W-1:0] vertex_x0;
      logic signed [COORD_FIELD_W-1:0] vertex_y0;
      logic signed [COORD_FIELD_W-1:0] vertex_x1;
      logic signed [COORD_FIELD_W-1:0] vertex_y1;
      logic signed [COORD_FIELD_W-1:0] vertex_x2;
      logic signed [COORD_FIELD_W-1:0] vertex_y2;
   } req_type;

   typedef struct packed {
      logic [1:0]                     row_vertex;
      logic signed [COEF_FIELD_W-1:0] stiff_col0;
      logic signed [COEF_FIELD_W-1:0] stiff_col1;
      logic signed [COEF_FIELD_W-1:0] stiff_col2;
      logic signed [COEF_FIELD_W-1:0] shape_const;
      logic signed [COEF_FIELD_W-1:0] shape_dx;
      logic signed [COEF_FIELD_W-1:0] shape_dy;
      logic signed [AREA_W-1:0]       twice_area;
      logic                           degenerate;
      logic                           last_row;
   } rsp_type;

   // Per-row information that travels beside the divider lanes.
   typedef struct packed {
      logic              valid;
      row_type           row;
      logic              last;
      logic              degen;
      logic [AREA_W-1:0] area;
   } side_type;

endpackage

// ===== sv/tes_front.sv =====
// Input register that takes one element and hands out its three vertex rows, one per cycle.
`timescale 1ns / 1ps
module tes_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tes_pkg::req_type req_data,
   output logic             row_vld,
   output tes_pkg::row_type row,
   output tes_pkg::req_type item
);

   tes_pkg::req_type item_ff, item_in;
   logic             vld_ff, vld_in;
   tes_pkg::row_type row_ff, row_in;
   logic             accept;

   // The element may be replaced while its last row goes out.
   assign busy   = vld_ff && (row_ff != tes_pkg::ROW_V2);
   assign accept = start && !busy;

   always_comb begin
      item_in = item_ff;
      vld_in  = vld_ff;
      row_in  = row_ff;
      if (accept) begin
         item_in = req_data;
         vld_in  = 1'b1;
         row_in  = tes_pkg::ROW_V0;
      end else if (vld_ff) begin
         case (row_ff)
            tes_pkg::ROW_V0: row_in = tes_pkg::ROW_V1;
            tes_pkg::ROW_V1: row_in = tes_pkg::ROW_V2;
            default: begin
               row_in = tes_pkg::ROW_V0;
               vld_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         vld_ff <= 1'b0;
         row_ff <= tes_pkg::ROW_V0;
      end else begin
         vld_ff <= vld_in;
         row_ff <= row_in;
      end
   end

   assign row_vld = vld_ff;
   assign row     = row_ff;
   assign item    = item_ff;

endmodule

// ===== sv/tes_prep.sv =====
// Four-stage datapath that forms edge terms, products, sums and divider operands of one row.
`timescale 1ns / 1ps
module tes_prep #(
   parameter int CW    = 32,
   parameter int NW    = 91,
   parameter int DEN_W = 67
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  row_vld,
   input  tes_pkg::row_type                      row,
   input  tes_pkg::req_type                      item,
   output logic [tes_pkg::LANES-1:0][NW-1:0]     num,
   output logic [DEN_W-1:0]                      den,
   output logic [tes_pkg::LANES-1:0]             neg,
   output tes_pkg::side_type                     side
);

   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int SW   = PW + 1;
   localparam int AW   = 2 * CW + 1;
   localparam int AEXT = (SW > tes_pkg::AREA_W) ? SW : tes_pkg::AREA_W + 1;
   localparam logic signed [AEXT-1:0] AMAX =
      $signed({{(AEXT - tes_pkg::AREA_W + 1){1'b0}}, {(tes_pkg::AREA_W-1){1'b1}}});
   localparam logic signed [AEXT-1:0] AMIN = ~AMAX;

   logic signed [CW-1:0] xv [3];
   logic signed [CW-1:0] yv [3];

   assign xv[0] = item.vertex_x0[CW-1:0];
   assign yv[0] = item.vertex_y0[CW-1:0];
   assign xv[1] = item.vertex_x1[CW-1:0];
   assign yv[1] = item.vertex_y1[CW-1:0];
   assign xv[2] = item.vertex_x2[CW-1:0];
   assign yv[2] = item.vertex_y2[CW-1:0];

   // Stage 1: differences and the row selection.
   logic signed [DW-1:0] b1_ff [3], b1_in [3], c1_ff [3], c1_in [3];
   logic signed [DW-1:0] ba1_ff, ba1_in, ca1_ff, ca1_in;
   logic signed [DW-1:0] dx1_ff, dx1_in, dy2_ff, dy2_in, dx2_ff, dx2_in, dy1_ff, dy1_in;
   logic signed [CW-1:0] xa_ff, xa_in, yb_ff, yb_in, xb_ff, xb_in, ya_ff, ya_in;
   tes_pkg::row_type     row1_ff;
   logic                 v1_ff;

   always_comb begin
      b1_in[0] = DW'(yv[1]) - DW'(yv[2]);
      b1_in[1] = DW'(yv[2]) - DW'(yv[0]);
      b1_in[2] = DW'(yv[0]) - DW'(yv[1]);
      c1_in[0] = DW'(xv[2]) - DW'(xv[1]);
      c1_in[1] = DW'(xv[0]) - DW'(xv[2]);
      c1_in[2] = DW'(xv[1]) - DW'(xv[0]);
      dx1_in   = DW'(xv[1]) - DW'(xv[0]);
      dy2_in   = DW'(yv[2]) - DW'(yv[0]);
      dx2_in   = DW'(xv[2]) - DW'(xv[0]);
      dy1_in   = DW'(yv[1]) - DW'(yv[0]);
      case (row)
         tes_pkg::ROW_V1: begin
            ba1_in = b1_in[1];
            ca1_in = c1_in[1];
            xa_in  = xv[2];
            yb_in  = yv[0];
            xb_in  = xv[0];
            ya_in  = yv[2];
         end
         tes_pkg::ROW_V2: begin
            ba1_in = b1_in[2];
            ca1_in = c1_in[2];
            xa_in  = xv[0];
            yb_in  = yv[1];
            xb_in  = xv[1];
            ya_in  = yv[0];
         end
         default: begin
            ba1_in = b1_in[0];
            ca1_in = c1_in[0];
            xa_in  = xv[1];
            yb_in  = yv[2];
            xb_in  = xv[2];
            ya_in  = yv[1];
         end
      endcase
   end

   // Stage 2: products.
   logic signed [PW-1:0]     pbb_ff [3], pbb_in [3], pcc_ff [3], pcc_in [3];
   logic signed [PW-1:0]     pd1_ff, pd1_in, pd2_ff, pd2_in;
   logic signed [2*CW-1:0]   pa1_ff, pa1_in, pa2_ff, pa2_in;
   logic signed [DW-1:0]     ba2_ff, ca2_ff;
   tes_pkg::row_type         row2_ff;
   logic                     v2_ff;

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         pbb_in[e] = PW'(ba1_ff) * PW'(b1_ff[e]);
         pcc_in[e] = PW'(ca1_ff) * PW'(c1_ff[e]);
      end
      pd1_in = PW'(dx1_ff) * PW'(dy2_ff);
      pd2_in = PW'(dx2_ff) * PW'(dy1_ff);
      pa1_in = (2*CW)'(xa_ff) * (2*CW)'(yb_ff);
      pa2_in = (2*CW)'(xb_ff) * (2*CW)'(ya_ff);
   end

   // Stage 3: sums.
   logic signed [SW-1:0] nk3_ff [3], nk3_in [3];
   logic signed [SW-1:0] d3_ff, d3_in;
   logic signed [AW-1:0] an3_ff, an3_in;
   logic signed [DW-1:0] ba3_ff, ca3_ff;
   tes_pkg::row_type     row3_ff;
   logic                 v3_ff;

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         nk3_in[e] = SW'(pbb_ff[e]) + SW'(pcc_ff[e]);
      end
      d3_in  = SW'(pd1_ff) - SW'(pd2_ff);
      an3_in = AW'(pa1_ff) - AW'(pa2_ff);
   end

   // Stage 4: magnitudes, aligned numerators, signs and the saturated area.
   logic [tes_pkg::LANES-1:0][NW-1:0] num_ff, num_in;
   logic [DEN_W-1:0]                  den_ff, den_in;
   logic [tes_pkg::LANES-1:0]         neg_ff, neg_in;
   tes_pkg::side_type                 side_ff, side_in;
   logic [SW-1:0]                     kmag [3];
   logic [AW-1:0]                     amag;
   logic [DW-1:0]                     bmag, cmag;
   logic                              dneg;
   logic signed [AEXT-1:0]            dext;

   always_comb begin
      dneg = d3_ff[SW-1];
      for (int e = 0; e < 3; e++) begin
         kmag[e] = nk3_ff[e][SW-1] ? $unsigned(-nk3_ff[e]) : $unsigned(nk3_ff[e]);
      end
      amag = an3_ff[AW-1] ? $unsigned(-an3_ff) : $unsigned(an3_ff);
      bmag = ba3_ff[DW-1] ? $unsigned(-ba3_ff) : $unsigned(ba3_ff);
      cmag = ca3_ff[DW-1] ? $unsigned(-ca3_ff) : $unsigned(ca3_ff);
      den_in = dneg ? DEN_W'($unsigned(-d3_ff)) : DEN_W'($unsigned(d3_ff));

      num_in[tes_pkg::LANE_K0]    = NW'(kmag[0]) << tes_pkg::K_SHIFT;
      num_in[tes_pkg::LANE_K1]    = NW'(kmag[1]) << tes_pkg::K_SHIFT;
      num_in[tes_pkg::LANE_K2]    = NW'(kmag[2]) << tes_pkg::K_SHIFT;
      num_in[tes_pkg::LANE_ALPHA] = NW'(amag) << tes_pkg::ALPHA_SHIFT;
      num_in[tes_pkg::LANE_BETA]  = NW'(bmag) << tes_pkg::SLOPE_SHIFT;
      num_in[tes_pkg::LANE_GAMMA] = NW'(cmag) << tes_pkg::SLOPE_SHIFT;

      // Stiffness divides by the absolute area, so only the numerator sign counts.
      neg_in[tes_pkg::LANE_K0]    = nk3_ff[0][SW-1];
      neg_in[tes_pkg::LANE_K1]    = nk3_ff[1][SW-1];
      neg_in[tes_pkg::LANE_K2]    = nk3_ff[2][SW-1];
      neg_in[tes_pkg::LANE_ALPHA] = an3_ff[AW-1] ^ dneg;
      neg_in[tes_pkg::LANE_BETA]  = ba3_ff[DW-1] ^ dneg;
      neg_in[tes_pkg::LANE_GAMMA] = ca3_ff[DW-1] ^ dneg;

      dext          = AEXT'(d3_ff);
      side_in.valid = v3_ff;
      side_in.row   = row3_ff;
      side_in.last  = (row3_ff == tes_pkg::ROW_V2);
      side_in.degen = (d3_ff == '0);
      if (dext > AMAX) begin
         side_in.area = tes_pkg::AREA_MAX;
      end else if (dext < AMIN) begin
         side_in.area = tes_pkg::AREA_MIN;
      end else begin
         side_in.area = dext[tes_pkg::AREA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      b1_ff   <= b1_in;
      c1_ff   <= c1_in;
      ba1_ff  <= ba1_in;
      ca1_ff  <= ca1_in;
      dx1_ff  <= dx1_in;
      dy2_ff  <= dy2_in;
      dx2_ff  <= dx2_in;
      dy1_ff  <= dy1_in;
      xa_ff   <= xa_in;
      yb_ff   <= yb_in;
      xb_ff   <= xb_in;
      ya_ff   <= ya_in;
      row1_ff <= row;

      pbb_ff  <= pbb_in;
      pcc_ff  <= pcc_in;
      pd1_ff  <= pd1_in;
      pd2_ff  <= pd2_in;
      pa1_ff  <= pa1_in;
      pa2_ff  <= pa2_in;
      ba2_ff  <= ba1_ff;
      ca2_ff  <= ca1_ff;
      row2_ff <= row1_ff;

      nk3_ff  <= nk3_in;
      d3_ff   <= d3_in;
      an3_ff  <= an3_in;
      ba3_ff  <= ba2_ff;
      ca3_ff  <= ca2_ff;
      row3_ff <= row2_ff;

      num_ff  <= num_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         side_ff.valid <= 1'b0;
      end else begin
         v1_ff   <= row_vld;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         side_ff <= side_in;
      end
   end

   assign num  = num_ff;
   assign den  = den_ff;
   assign neg  = neg_ff;
   assign side = side_ff;

endmodule

// ===== sv/tes_div.sv =====
// Pipelined restoring divider lane, one quotient bit per stage, with signed saturation.
`timescale 1ns / 1ps
module tes_div #(
   parameter int NW    = 91,
   parameter int DEN_W = 67,
   parameter int QW    = 48
) (
   input  logic             clock,
   input  logic [NW-1:0]    num,
   input  logic [DEN_W-1:0] den,
   input  logic             neg,
   output logic [QW-1:0]    res
);

   localparam int HW   = NW - QW;
   localparam int CMPW = (HW > DEN_W) ? HW : DEN_W;

   logic [DEN_W-1:0] rem_ff [QW+1], rem_in [QW+1];
   logic [QW-1:0]    lq_ff  [QW+1], lq_in  [QW+1];
   logic [DEN_W-1:0] den_ff [QW+1], den_in [QW+1];
   logic             neg_ff [QW+1], neg_in [QW+1];
   logic             ovf_ff [QW+1], ovf_in [QW+1];
   logic [QW-1:0]    res_ff, res_in;
   logic [HW-1:0]    hi;
   logic [DEN_W:0]   trial [QW];
   logic             ge    [QW];
   logic [QW-1:0]    q;
   logic             sat;

   always_comb begin
      // A quotient that needs more than QW bits saturates; otherwise the high part
      // of the numerator is already a valid partial remainder.
      hi        = num[NW-1:QW];
      ovf_in[0] = (CMPW'(hi) >= CMPW'(den));
      rem_in[0] = ovf_in[0] ? '0 : DEN_W'(hi);
      lq_in[0]  = num[QW-1:0];
      den_in[0] = den;
      neg_in[0] = neg;
      for (int k = 0; k < QW; k++) begin
         trial[k]    = {rem_ff[k], lq_ff[k][QW-1]};
         ge[k]       = trial[k] >= {1'b0, den_ff[k]};
         rem_in[k+1] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_ff[k]}) : trial[k][DEN_W-1:0];
         lq_in[k+1]  = {lq_ff[k][QW-2:0], ge[k]};
         den_in[k+1] = den_ff[k];
         neg_in[k+1] = neg_ff[k];
         ovf_in[k+1] = ovf_ff[k];
      end
      q = lq_ff[QW];
      if (neg_ff[QW]) begin
         sat    = ovf_ff[QW] || (q[QW-1] && (|q[QW-2:0]));
         res_in = sat ? {1'b1, {(QW-1){1'b0}}} : (~q + 1'b1);
      end else begin
         sat    = ovf_ff[QW] || q[QW-1];
         res_in = sat ? {1'b0, {(QW-1){1'b1}}} : q;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lq_ff  <= lq_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

// ===== sv/triangle_element_stiffness_top.sv =====
// Top level of the linear triangle element stiffness and shape coefficient block.
`timescale 1ns / 1ps
// The block takes one triangle as a word on req_data: three vertices in signed Q16.16.
// A word is accepted at a rising clock edge where start is high and busy is low.
// For each triangle it returns three words on rsp_data, one per vertex in vertex order,
// each present for exactly one cycle with rsp_strobe high. A word carries the vertex's
// stiffness row, its shape coefficients alpha, beta and gamma (Q24.24, saturated), the
// signed twice-area (Q32.32, saturated) and the degenerate and last_row flags.
// A triangle occupies the input register while its vertex rows go out, one per cycle,
// so no new triangle is taken before the last of them; busy is low again in the cycle
// that sends out the third row, and a held start then gives back-to-back rows with no gap.
// Each row runs through a four-stage arithmetic pipeline, then six divider lanes that
// resolve one quotient bit per stage, then an output register. The three words of a
// triangle leave back to back, in the order in which their rows entered.
// The receiver cannot hold words off; nothing inside ever stalls.
// Reset is synchronous and clears every valid bit, so no word comes out of reset.
module triangle_element_stiffness_top #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH  = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tes_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tes_pkg::rsp_type rsp_data
);

   // Numerator and denominator widths that cover every lane.
   localparam int NW_BASE = 2 * COORD_WIDTH + 27;
   localparam int NW      = (NW_BASE > COEF_WIDTH) ? NW_BASE : COEF_WIDTH + 1;
   localparam int DEN_W   = 2 * COORD_WIDTH + 3;
   localparam int DLY     = COEF_WIDTH + 2;

   logic                                   row_vld;
   tes_pkg::row_type                       row;
   tes_pkg::req_type                       item;
   logic [tes_pkg::LANES-1:0][NW-1:0]      num;
   logic [DEN_W-1:0]                       den;
   logic [tes_pkg::LANES-1:0]              neg;
   tes_pkg::side_type                      side;
   logic [tes_pkg::LANES-1:0][COEF_WIDTH-1:0] res;

   tes_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .row_vld  (row_vld),
      .row      (row),
      .item     (item)
   );

   tes_prep #(
      .CW    (COORD_WIDTH),
      .NW    (NW),
      .DEN_W (DEN_W)
   ) u_prep (
      .clock   (clock),
      .reset   (reset),
      .row_vld (row_vld),
      .row     (row),
      .item    (item),
      .num     (num),
      .den     (den),
      .neg     (neg),
      .side    (side)
   );

   for (genvar g = 0; g < tes_pkg::LANES; g++) begin : g_lane
      tes_div #(
         .NW    (NW),
         .DEN_W (DEN_W),
         .QW    (COEF_WIDTH)
      ) u_div (
         .clock (clock),
         .num   (num[g]),
         .den   (den),
         .neg   (neg[g]),
         .res   (res[g])
      );
   end

   // The row's flags and area wait beside the divider lanes.
   tes_pkg::side_type side_ff [DLY], side_in [DLY];

   always_comb begin
      side_in[0] = side;
      for (int i = 1; i < DLY; i++) begin
         side_in[i] = side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DLY; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else begin
         side_ff <= side_in;
      end
   end

   // Output register; a zero area forces every coefficient to zero.
   tes_pkg::rsp_type  rsp_ff, rsp_in;
   logic              strobe_ff;
   tes_pkg::side_type so;

   always_comb begin
      so                 = side_ff[DLY-1];
      rsp_in.row_vertex  = so.row;
      rsp_in.twice_area  = so.area;
      rsp_in.degenerate  = so.degen;
      rsp_in.last_row    = so.last;
      if (so.degen) begin
         rsp_in.stiff_col0  = '0;
         rsp_in.stiff_col1  = '0;
         rsp_in.stiff_col2  = '0;
         rsp_in.shape_const = '0;
         rsp_in.shape_dx    = '0;
         rsp_in.shape_dy    = '0;
      end else begin
         rsp_in.stiff_col0  = tes_pkg::COEF_FIELD_W'(res[tes_pkg::LANE_K0]);
         rsp_in.stiff_col1  = tes_pkg::COEF_FIELD_W'(res[tes_pkg::LANE_K1]);
         rsp_in.stiff_col2  = tes_pkg::COEF_FIELD_W'(res[tes_pkg::LANE_K2]);
         rsp_in.shape_const = tes_pkg::COEF_FIELD_W'(res[tes_pkg::LANE_ALPHA]);
         rsp_in.shape_dx    = tes_pkg::COEF_FIELD_W'(res[tes_pkg::LANE_BETA]);
         rsp_in.shape_dy    = tes_pkg::COEF_FIELD_W'(res[tes_pkg::LANE_GAMMA]);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= so.valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
